/* sv/lcdw_pkg.sv */
// Shared types, codes and constants of the four-bit LCD write sequencer.
// Depends on nothing; every other file of the block uses it.
package lcdw_pkg;

	localparam int BYTE_W    = 8;
	localparam int NIBBLE_W  = 4;
	localparam int PULSE_W   = 8;
	localparam int WAIT_W    = 16;
	localparam int INIT_W    = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [INIT_W-1:0]  INIT_COUNT         = 3'd6;
	localparam logic [BYTE_W-1:0]  CLEAR_CMD          = 8'h01;
	localparam logic [PULSE_W-1:0] ENABLE_PULSE_RESET = 8'd40;
	localparam logic [WAIT_W-1:0]  CLEAR_WAIT_RESET   = 16'd3000;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PULSE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT   = 1'b1;

	typedef enum logic {
		ITEM_TICK  = 1'b0,
		ITEM_WRITE = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t        kind;
		logic              rs;
		logic [BYTE_W-1:0] byte_value;
	} item_t;

	typedef struct packed {
		logic                pin_rs;
		logic                pin_enable;
		logic [NIBBLE_W-1:0] pin_data;
		logic                busy_res;
		logic                rejected;
	} result_t;

	function automatic logic [BYTE_W-1:0] init_cmd(input logic [INIT_W-1:0] idx);
		logic [BYTE_W-1:0] cmd;
		case (idx)
			3'd0: cmd = 8'h33;
			3'd1: cmd = 8'h32;
			3'd2: cmd = 8'h28;
			3'd3: cmd = 8'h0C;
			3'd4: cmd = 8'h06;
			3'd5: cmd = 8'h01;
			default: cmd = 8'h00;
		endcase
		return cmd;
	endfunction

endpackage

/* sv/lcdw_if.sv */
// Handshake channels of the LCD write sequencer: request, result and register write.
// Depends on lcdw_pkg for field widths.
interface lcdw_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic                         reg_select;
	logic [lcdw_pkg::BYTE_W-1:0]  byte_value;

	modport source (output valid, req_type, reg_select, byte_value, input ready);
	modport sink   (input valid, req_type, reg_select, byte_value, output ready);
endinterface

interface lcdw_res_if;
	logic                          valid;
	logic                          ready;
	logic                          pin_rs;
	logic                          pin_enable;
	logic [lcdw_pkg::NIBBLE_W-1:0] pin_data;
	logic                          busy_res;
	logic                          rejected;

	modport source (output valid, pin_rs, pin_enable, pin_data, busy_res, rejected, input ready);
	modport sink   (input valid, pin_rs, pin_enable, pin_data, busy_res, rejected, output ready);
endinterface

interface lcdw_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lcdw_pkg::CFG_IDX_W-1:0] index;
	logic [lcdw_pkg::WAIT_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* sv/lcd_four_bit_write_sequencer.sv */
// Top level of the four-bit character LCD write sequencer.
// Depends on lcdw_pkg, lcdw_if, lcdw_front, lcdw_queue and lcdw_back.
//
// Channels: req takes words that are either a one-microsecond tick (req_type 0)
// or a byte write (req_type 1, reg_select and byte_value). res returns one word
// per request: the levels of RS, enable and D4..D7, busy, and a rejected flag
// set when a write arrived during init, a transfer or a wait. cfg writes
// enable_pulse_ticks (index 0) and clear_wait_ticks (index 1); it is always ready
// and should be written only while no request is in flight.
// A request passes the front stage register, the queue and the result register.
// Throughput: one request per cycle while res.ready is high; the front stage, a
// two-entry queue and the result register each take one word per cycle.
// Reset: the sequencer starts the six-command init at once, driven by ticks,
// and ends it with the clear wait; writes during that time are rejected.
// Receiver stall: the result register holds; the queue and front stage absorb
// three more requests before req.ready drops.
module lcd_four_bit_write_sequencer (
	input logic   clk,
	input logic   arst_n,
	lcdw_req_if.sink   req,
	lcdw_res_if.source res,
	lcdw_cfg_if.sink   cfg
);

	logic              push_valid;
	logic              push_ready;
	lcdw_pkg::item_t   push_item;
	logic              pop_valid;
	logic              pop_ready;
	lcdw_pkg::item_t   pop_item;
	lcdw_pkg::result_t res_word;

	assign cfg.ready      = 1'b1;
	assign res.pin_rs     = res_word.pin_rs;
	assign res.pin_enable = res_word.pin_enable;
	assign res.pin_data   = res_word.pin_data;
	assign res.busy_res   = res_word.busy_res;
	assign res.rejected   = res_word.rejected;

	lcdw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_type   (req.req_type),
		.reg_select (req.reg_select),
		.byte_value (req.byte_value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	lcdw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	lcdw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.item       (pop_item),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.res_valid  (res.valid),
		.res_ready  (res.ready),
		.res        (res_word)
	);

endmodule

/* sv/lcdw_front.sv */
// Front stage: accepts request words, classifies them as tick or write and stages them.
// Depends on lcdw_pkg; feeds lcdw_queue.
module lcdw_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic                        req_type,
	input  logic                        reg_select,
	input  logic [lcdw_pkg::BYTE_W-1:0] byte_value,
	output logic                        push_valid,
	input  logic                        push_ready,
	output lcdw_pkg::item_t             push_item
);

	logic            valid_s1;
	lcdw_pkg::item_t item_s1;
	lcdw_pkg::item_t item_d;

	assign req_ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_comb begin
		item_d.kind       = req_type ? lcdw_pkg::ITEM_WRITE : lcdw_pkg::ITEM_TICK;
		item_d.rs         = req_type & reg_select;
		item_d.byte_value = req_type ? byte_value : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* sv/lcdw_queue.sv */
// Two-entry queue between the front stage and the pin sequencer.
// Depends on lcdw_pkg for the item type.
module lcdw_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  lcdw_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output lcdw_pkg::item_t pop_item
);

	lcdw_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* sv/lcdw_back.sv */
// Pin sequencer: runs init, nibble strobes and clear waits, one queued word per cycle unless a stalled result holds it.
// Holds the timing registers and the result register. Depends on lcdw_pkg.
module lcdw_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  lcdw_pkg::item_t                item,
	input  logic                           cfg_we,
	input  logic [lcdw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lcdw_pkg::WAIT_W-1:0]    cfg_data,
	output logic                           res_valid,
	input  logic                           res_ready,
	output lcdw_pkg::result_t              res
);

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_INIT_START = 3'd1,
		PH_HI_PULSE   = 3'd2,
		PH_LO_SETUP   = 3'd3,
		PH_LO_PULSE   = 3'd4,
		PH_WAIT       = 3'd5
	} phase_t;

	phase_t                             phase_q, phase_n;
	logic [lcdw_pkg::WAIT_W-1:0]        count_q, count_n, count_inc;
	logic [lcdw_pkg::BYTE_W-1:0]        byte_q, byte_n;
	logic                               rs_q, rs_n;
	logic [lcdw_pkg::INIT_W-1:0]        init_idx_q, init_idx_n;
	logic [lcdw_pkg::NIBBLE_W-1:0]      nibble_q, nibble_n;
	logic                               enable_q, enable_n;
	logic [lcdw_pkg::PULSE_W-1:0]       pulse_q;
	logic [lcdw_pkg::WAIT_W-1:0]        wait_q;
	logic                               res_valid_q;
	lcdw_pkg::result_t                  res_q;
	logic                               busy;
	logic                               rejected_n;
	logic                               is_clear;
	logic [lcdw_pkg::BYTE_W-1:0]        init_byte;
	logic                               step;

	assign item_ready = !res_valid_q || res_ready;
	assign step       = item_valid && item_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign busy       = (phase_q != PH_IDLE);
	assign count_inc  = (count_q == '1) ? count_q : count_q + 16'd1;
	assign is_clear   = !rs_q && (byte_q == lcdw_pkg::CLEAR_CMD);
	assign init_byte  = lcdw_pkg::init_cmd(init_idx_q);

	always_comb begin
		phase_n    = phase_q;
		count_n    = count_q;
		byte_n     = byte_q;
		rs_n       = rs_q;
		init_idx_n = init_idx_q;
		nibble_n   = nibble_q;
		enable_n   = enable_q;
		rejected_n = 1'b0;
		if (item.kind == lcdw_pkg::ITEM_WRITE) begin
			if (busy) begin
				rejected_n = 1'b1;
			end else begin
				byte_n   = item.byte_value;
				rs_n     = item.rs;
				nibble_n = item.byte_value[7:4];
				enable_n = 1'b1;
				count_n  = '0;
				phase_n  = PH_HI_PULSE;
			end
		end else begin
			case (phase_q)
				PH_INIT_START: begin
					if (init_idx_q < lcdw_pkg::INIT_COUNT) begin
						byte_n   = init_byte;
						rs_n     = 1'b0;
						nibble_n = init_byte[7:4];
						enable_n = 1'b1;
						count_n  = '0;
						phase_n  = PH_HI_PULSE;
					end else begin
						phase_n = PH_IDLE;
					end
				end
				PH_HI_PULSE: begin
					count_n = count_inc;
					if (count_inc >= {8'd0, pulse_q}) begin
						enable_n = 1'b0;
						nibble_n = byte_q[3:0];
						count_n  = '0;
						phase_n  = PH_LO_SETUP;
					end
				end
				PH_LO_SETUP: begin
					enable_n = 1'b1;
					count_n  = '0;
					phase_n  = PH_LO_PULSE;
				end
				PH_LO_PULSE: begin
					count_n = count_inc;
					if (count_inc >= {8'd0, pulse_q}) begin
						enable_n = 1'b0;
						count_n  = '0;
						if (init_idx_q < lcdw_pkg::INIT_COUNT) begin
							init_idx_n = init_idx_q + 3'd1;
						end
						if (is_clear) begin
							phase_n = PH_WAIT;
						end else if (init_idx_n < lcdw_pkg::INIT_COUNT) begin
							phase_n = PH_INIT_START;
						end else begin
							phase_n = PH_IDLE;
						end
					end
				end
				PH_WAIT: begin
					count_n = count_inc;
					if (count_inc >= wait_q) begin
						count_n = '0;
						phase_n = (init_idx_q < lcdw_pkg::INIT_COUNT) ? PH_INIT_START : PH_IDLE;
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_INIT_START;
			count_q     <= '0;
			byte_q      <= '0;
			rs_q        <= 1'b0;
			init_idx_q  <= '0;
			nibble_q    <= '0;
			enable_q    <= 1'b0;
			pulse_q     <= lcdw_pkg::ENABLE_PULSE_RESET;
			wait_q      <= lcdw_pkg::CLEAR_WAIT_RESET;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == lcdw_pkg::CFG_ENABLE_PULSE) begin
					pulse_q <= cfg_data[lcdw_pkg::PULSE_W-1:0];
				end else begin
					wait_q <= cfg_data;
				end
			end
			if (step) begin
				phase_q          <= phase_n;
				count_q          <= count_n;
				byte_q           <= byte_n;
				rs_q             <= rs_n;
				init_idx_q       <= init_idx_n;
				nibble_q         <= nibble_n;
				enable_q         <= enable_n;
				res_q.pin_rs     <= rs_n;
				res_q.pin_enable <= enable_n;
				res_q.pin_data   <= nibble_n;
				res_q.busy_res   <= (phase_n != PH_IDLE);
				res_q.rejected   <= rejected_n;
				res_valid_q      <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/lcdw_checker.sv */
// Port-level checks of the LCD write sequencer, attached to the top level by bind.
// Depends on lcdw_pkg and lcd_four_bit_write_sequencer.
module lcdw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          pin_rs,
	input logic                          pin_enable,
	input logic [lcdw_pkg::NIBBLE_W-1:0] pin_data,
	input logic                          busy_res,
	input logic                          rejected,
	input logic                          cfg_ready
);

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && rejected |-> busy_res)
		else $error("rejected word while not busy");

	a_enable_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pin_enable |-> busy_res)
		else $error("enable high while idle");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(pin_rs) && $stable(pin_enable)
			&& $stable(pin_data) && $stable(busy_res) && $stable(rejected))
		else $error("stalled result word changed");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register port not ready");

endmodule

bind lcd_four_bit_write_sequencer lcdw_checker u_lcdw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.pin_rs     (res.pin_rs),
	.pin_enable (res.pin_enable),
	.pin_data   (res.pin_data),
	.busy_res   (res.busy_res),
	.rejected   (res.rejected),
	.cfg_ready  (cfg.ready)
);
